// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the sine and cosine unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SCPU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scpu assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define SCPU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scpu assertion failed");

`endif

// ----- hw/rtl/scpu_pkg.sv -----
// shared constants, coefficient tables and types of the sine and cosine unit
`timescale 1ns / 1ps

package scpu_pkg;

	// fixed-point formats
	localparam int AFB = 24;                 // angle fraction bits
	localparam int OFB = 30;                 // result fraction bits
	localparam int UP = 30 - AFB;            // angle format to q30
	localparam int OUT_RND = 32 - OFB;       // final rounding shift

	// pi at q62
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

	// derived angle constants
	localparam logic [63:0] TAU_A = (PI_Q62 + (64'd1 << (60 - AFB))) >> (61 - AFB);
	localparam logic [63:0] PI30 = (PI_Q62 + (64'd1 << 31)) >> 32;
	localparam logic [63:0] HALF30 = (PI_Q62 + (64'd1 << 32)) >> 33;
	localparam logic [63:0] TAU30 = TAU_A << UP;

	// reciprocal of tau for the quotient estimate
	localparam int RECIP_SH = 40;
	localparam int RECIP_W = 24;
	localparam logic [63:0] RECIP = (64'd1 << RECIP_SH) / TAU_A;

	// datapath widths
	localparam int P1_W = 32 + RECIP_W + 1;  // angle times reciprocal
	localparam int Q_W = P1_W - RECIP_SH;    // quotient estimate
	localparam int QT_W = Q_W + 32;          // quotient times tau
	localparam int R_W = 40;                 // uncorrected remainder
	localparam int RED_W = 31;               // reduced angle, below tau
	localparam int F_W = 35;                 // q30 fold arithmetic
	localparam int X_W = 32;
	localparam int S_W = 32;
	localparam int ACC_W = 34;
	localparam int PROD_W = ACC_W + S_W + 1;
	localparam int SP_W = X_W + ACC_W;       // sine final product
	localparam int Y_W = 36;

	// signed forms of the constants
	localparam logic signed [RECIP_W:0] RECIP_S = (RECIP_W + 1)'(RECIP);
	localparam logic signed [31:0] TAU_S = 32'(TAU_A);
	localparam logic signed [R_W-1:0] TAU_R = R_W'(TAU_A);
	localparam logic [RED_W-1:0] TAU_U = RED_W'(TAU_A);
	localparam logic signed [F_W-1:0] PI30_S = F_W'(PI30);
	localparam logic signed [F_W-1:0] HALF30_S = F_W'(HALF30);
	localparam logic signed [F_W-1:0] PIH30_S = F_W'(PI30 + HALF30);
	localparam logic signed [F_W-1:0] TAU30_S = F_W'(TAU30);
	localparam logic signed [X_W-1:0] X_MAX_S = X_W'(HALF30 + (64'd1 << UP));
	localparam logic [63:0] HALF_LSB30 = 64'd1 << 29;
	localparam logic [63:0] HALF_LSB_OUT = 64'd1 << (OUT_RND - 1);
	localparam logic signed [31:0] OUT_LIM_S = 32'(64'd1 << OFB);

	// horner coefficients at q32, add terms already carry their sign
	localparam int N_STEPS = 5;
	localparam logic signed [ACC_W-1:0] SIN_C0 = -34'sd103;
	localparam logic signed [ACC_W-1:0] COS_C0 = -34'sd1119;
	localparam logic signed [ACC_W-1:0] SIN_ADD [N_STEPS] = '{
		34'sd11822, -34'sd852160, 34'sd35791386, -34'sd715827882, 34'sd4294967296
	};
	localparam logic signed [ACC_W-1:0] COS_ADD [N_STEPS] = '{
		34'sd106347, -34'sd5965021, 34'sd178956864, -34'sd2147483632, 34'sd4294967296
	};

	// pipeline depth: reduction and fold, two stages per horner step, output
	localparam int NST = 7 + 2 * N_STEPS + 3;
	localparam int MID = NST / 2;

	// per-item data that rides along the horner steps
	typedef struct packed {
		logic                  mode;
		logic                  neg;
		logic signed [X_W-1:0] x;
		logic [S_W-1:0]        s;
	} side_t;

	// stage enables of one horner step
	typedef struct packed {
		logic en_mul;
		logic en_add;
	} step_en_t;

endpackage

// ----- hw/rtl/sine_cosine_polynomial_unit.sv -----
// top level of the pipelined fixed-point sine and cosine unit
// a transaction passes through the reduction, fold, horner and output stages to the output register
// throughput: one transaction per cycle while backpressure does not stall the pipeline, every stage holds one item
// backpressure: a stage advances when out_ready is high or it or a later stage is empty
// reset clears the stage valid bits only; the data registers are not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sine_cosine_polynomial_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	input  logic               mode,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value
);

	localparam int NST = scpu_pkg::NST;
	localparam logic signed [31:0] OUT_LIM = scpu_pkg::OUT_LIM_S;

	// stage valid bits and enables
	logic [NST:1]   v_q;
	logic [NST:1]   v_prev;
	logic [NST:1]   en;

	// reduction and fold stages
	logic signed [scpu_pkg::P1_W-1:0]  p1_s1;
	logic signed [31:0]                a_s1;
	logic                              mode_s1;
	logic signed [scpu_pkg::QT_W-1:0]  qt_s2;
	logic signed [31:0]                a_s2;
	logic                              mode_s2;
	logic signed [scpu_pkg::R_W-1:0]   rraw_s3;
	logic                              mode_s3;
	logic [scpu_pkg::RED_W-1:0]        r_s4;
	logic                              mode_s4;
	logic signed [scpu_pkg::X_W-1:0]   x_s5;
	logic                              neg_s5;
	logic                              mode_s5;
	logic signed [63:0]                xx_s6;
	logic signed [scpu_pkg::X_W-1:0]   x_s6;
	logic                              neg_s6;
	logic                              mode_s6;
	scpu_pkg::side_t                   side_s7;
	logic signed [scpu_pkg::ACC_W-1:0] acc0_s7;

	// combinational helpers
	logic signed [scpu_pkg::Q_W-1:0]   q_est;
	logic signed [scpu_pkg::QT_W-1:0]  diff;
	logic signed [scpu_pkg::R_W-1:0]   r_fix;
	logic signed [scpu_pkg::F_W-1:0]   r30;
	logic signed [scpu_pkg::F_W-1:0]   x_fold;
	logic                              neg_fold;
	logic signed [63:0]                xx_rnd;

	// horner chain
	logic signed [scpu_pkg::ACC_W-1:0] acc_c [scpu_pkg::N_STEPS+1];
	scpu_pkg::side_t                   side_c [scpu_pkg::N_STEPS+1];

	// output stages
	logic signed [scpu_pkg::SP_W-1:0]  prod_s18;
	logic signed [scpu_pkg::ACC_W-1:0] acc_s18;
	scpu_pkg::side_t                   side_s18;
	logic signed [scpu_pkg::Y_W-1:0]   y_s19;
	logic signed [scpu_pkg::SP_W-1:0]  sp_rnd;
	logic signed [scpu_pkg::SP_W-1:0]  sp_sh;
	logic signed [scpu_pkg::Y_W-1:0]   y_next;
	logic signed [scpu_pkg::Y_W-1:0]   yo_rnd;
	logic signed [scpu_pkg::Y_W-1:0]   yo_sh;
	logic signed [31:0]                value_s20;

	// stage enables: a stage may load when out_ready is high or some stage from it onward is empty
	genvar k;
	generate
		for (k = 1; k <= NST; k++) begin : g_en
			assign en[k] = out_ready | ~(&v_q[NST:k]);
		end
	endgenerate

	assign v_prev = {v_q[NST-1:1], in_valid};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 1; i <= NST; i++) begin
				if (en[i]) begin
					v_q[i] <= v_prev[i];
				end
			end
		end
	end

	assign in_ready = en[1];
	assign out_valid = v_q[NST];
	assign value = value_s20;

	// stage 1: quotient estimate product
	always_ff @(posedge clk) begin
		if (en[1]) begin
			p1_s1 <= angle * scpu_pkg::RECIP_S;
			a_s1 <= angle;
			mode_s1 <= mode;
		end
	end

	// stage 2: quotient times tau
	assign q_est = p1_s1[scpu_pkg::P1_W-1:scpu_pkg::RECIP_SH];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qt_s2 <= q_est * scpu_pkg::TAU_S;
			a_s2 <= a_s1;
			mode_s2 <= mode_s1;
		end
	end

	// stage 3: remainder before correction, lies in [-tau, 2 tau)
	assign diff = scpu_pkg::QT_W'(a_s2) - qt_s2;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			rraw_s3 <= diff[scpu_pkg::R_W-1:0];
			mode_s3 <= mode_s2;
		end
	end

	// stage 4: correct the remainder into [0, tau)
	always_comb begin
		if (rraw_s3 < 0) begin
			r_fix = rraw_s3 + scpu_pkg::TAU_R;
		end else if (rraw_s3 >= scpu_pkg::TAU_R) begin
			r_fix = rraw_s3 - scpu_pkg::TAU_R;
		end else begin
			r_fix = rraw_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			r_s4 <= r_fix[scpu_pkg::RED_W-1:0];
			mode_s4 <= mode_s3;
		end
	end

	// stage 5: move to q30 and fold by quadrant
	always_comb begin
		r30 = $signed({4'b0, r_s4}) <<< scpu_pkg::UP;
		if (r30 < scpu_pkg::PI30_S) begin
			if (r30 > scpu_pkg::HALF30_S) begin
				x_fold = scpu_pkg::PI30_S - r30;
				neg_fold = 1'b1;
			end else begin
				x_fold = r30;
				neg_fold = 1'b0;
			end
		end else if (r30 > scpu_pkg::PIH30_S) begin
			x_fold = r30 - scpu_pkg::TAU30_S;
			neg_fold = 1'b0;
		end else begin
			x_fold = scpu_pkg::PI30_S - r30;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			x_s5 <= x_fold[scpu_pkg::X_W-1:0];
			neg_s5 <= neg_fold;
			mode_s5 <= mode_s4;
		end
	end

	// stage 6: square of the folded angle
	always_ff @(posedge clk) begin
		if (en[6]) begin
			xx_s6 <= x_s5 * x_s5;
			x_s6 <= x_s5;
			neg_s6 <= neg_s5;
			mode_s6 <= mode_s5;
		end
	end

	// stage 7: round s to q30 and load the leading coefficient
	assign xx_rnd = (xx_s6 + $signed(scpu_pkg::HALF_LSB30)) >>> 30;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			side_s7.mode <= mode_s6;
			side_s7.neg <= neg_s6;
			side_s7.x <= x_s6;
			side_s7.s <= xx_rnd[scpu_pkg::S_W-1:0];
			acc0_s7 <= mode_s6 ? scpu_pkg::COS_C0 : scpu_pkg::SIN_C0;
		end
	end

	// stages 8 to 17: horner steps
	assign acc_c[0] = acc0_s7;
	assign side_c[0] = side_s7;

	genvar j;
	generate
		for (j = 0; j < scpu_pkg::N_STEPS; j++) begin : g_step
			scpu_pkg::step_en_t step_en;
			assign step_en.en_mul = en[8 + 2 * j];
			assign step_en.en_add = en[9 + 2 * j];

			scpu_horner_step u_step (
				.clk      (clk),
				.en       (step_en),
				.acc_in   (acc_c[j]),
				.side_in  (side_c[j]),
				.add_sin  (scpu_pkg::SIN_ADD[j]),
				.add_cos  (scpu_pkg::COS_ADD[j]),
				.acc_out  (acc_c[j+1]),
				.side_out (side_c[j+1])
			);
		end
	endgenerate

	// stage 18: sine product x times polynomial
	always_ff @(posedge clk) begin
		if (en[NST-2]) begin
			prod_s18 <= side_c[scpu_pkg::N_STEPS].x * acc_c[scpu_pkg::N_STEPS];
			acc_s18 <= acc_c[scpu_pkg::N_STEPS];
			side_s18 <= side_c[scpu_pkg::N_STEPS];
		end
	end

	// stage 19: q32 result, rounded sine product or signed cosine
	always_comb begin
		sp_rnd = prod_s18 + $signed(scpu_pkg::SP_W'(scpu_pkg::HALF_LSB30));
		sp_sh = sp_rnd >>> 30;
		if (side_s18.mode) begin
			y_next = side_s18.neg ? -scpu_pkg::Y_W'(acc_s18) : scpu_pkg::Y_W'(acc_s18);
		end else begin
			y_next = sp_sh[scpu_pkg::Y_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			y_s19 <= y_next;
		end
	end

	// stage 20: round to the output format and saturate
	always_comb begin
		yo_rnd = y_s19 + $signed(scpu_pkg::Y_W'(scpu_pkg::HALF_LSB_OUT));
		yo_sh = yo_rnd >>> scpu_pkg::OUT_RND;
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			if (yo_sh > scpu_pkg::Y_W'(scpu_pkg::OUT_LIM_S)) begin
				value_s20 <= scpu_pkg::OUT_LIM_S;
			end else if (yo_sh < -scpu_pkg::Y_W'(scpu_pkg::OUT_LIM_S)) begin
				value_s20 <= -scpu_pkg::OUT_LIM_S;
			end else begin
				value_s20 <= yo_sh[31:0];
			end
		end
	end

	// checks
	`SCPU_ASSERT_IMP(a_out_range, out_valid, (value <= OUT_LIM) && (value >= -OUT_LIM))
	`SCPU_ASSERT_IMP(a_reduced_range, v_q[4], r_s4 < scpu_pkg::TAU_U)
	`SCPU_ASSERT_IMP(a_fold_range, v_q[5], (x_s5 <= scpu_pkg::X_MAX_S) && (x_s5 >= -scpu_pkg::X_MAX_S))
	`SCPU_ASSERT_IMP(a_ready_when_drained, !v_q[NST], in_ready)
	`SCPU_ASSERT_NXT(a_mid_hold, v_q[scpu_pkg::MID] && !en[scpu_pkg::MID], v_q[scpu_pkg::MID])

endmodule

// ----- hw/rtl/scpu_horner_step.sv -----
// one horner step: multiply by s, round to q32, add the coefficient
`timescale 1ns / 1ps

module scpu_horner_step (
	input  logic                                 clk,
	input  scpu_pkg::step_en_t                   en,
	input  logic signed [scpu_pkg::ACC_W-1:0]    acc_in,
	input  scpu_pkg::side_t                      side_in,
	input  logic signed [scpu_pkg::ACC_W-1:0]    add_sin,
	input  logic signed [scpu_pkg::ACC_W-1:0]    add_cos,
	output logic signed [scpu_pkg::ACC_W-1:0]    acc_out,
	output scpu_pkg::side_t                      side_out
);

	logic signed [scpu_pkg::PROD_W-1:0] prod_s1;
	scpu_pkg::side_t                    side_s1;
	logic signed [scpu_pkg::PROD_W-1:0] rnd;
	logic signed [scpu_pkg::PROD_W-1:0] shifted;
	logic signed [scpu_pkg::ACC_W-1:0]  addend;
	logic signed [scpu_pkg::ACC_W-1:0]  acc_s2;
	scpu_pkg::side_t                    side_s2;

	// multiply stage
	always_ff @(posedge clk) begin
		if (en.en_mul) begin
			prod_s1 <= acc_in * $signed({1'b0, side_in.s});
			side_s1 <= side_in;
		end
	end

	// round half up by 2^30 and pick the coefficient for the mode
	always_comb begin
		rnd = prod_s1 + $signed(scpu_pkg::PROD_W'(scpu_pkg::HALF_LSB30));
		shifted = rnd >>> 30;
		addend = side_s1.mode ? add_cos : add_sin;
	end

	// add stage
	always_ff @(posedge clk) begin
		if (en.en_add) begin
			acc_s2 <= shifted[scpu_pkg::ACC_W-1:0] + addend;
			side_s2 <= side_s1;
		end
	end

	assign acc_out = acc_s2;
	assign side_out = side_s2;

endmodule

// ----- sim/sine_cosine_polynomial_unit_tb.sv -----
// self-checking testbench for the pipelined sine and cosine unit
`timescale 1ns / 1ps

// predicts each result and checks results in order against the predictions
class sincos_scoreboard;
	localparam int ANGLE_FB = 24;
	localparam int OUT_FB = 30;
	localparam int UP_SH = 30 - ANGLE_FB;
	localparam bit [63:0] PI_BITS = 64'hC90FDAA22168C234;
	localparam longint TAU_Q24 =
		longint'((PI_BITS + (64'd1 << (60 - ANGLE_FB))) >> (61 - ANGLE_FB));
	localparam longint PI_Q30 = longint'((PI_BITS + (64'd1 << 31)) >> 32);
	localparam longint HALF_PI_Q30 = longint'((PI_BITS + (64'd1 << 32)) >> 33);
	localparam longint TAU_Q30 = TAU_Q24 <<< UP_SH;

	logic signed [31:0] pending_value [$];
	logic signed [31:0] pending_angle [$];
	logic pending_mode [$];
	int errors = 0;
	int checked = 0;
	int sine_count = 0;
	int cosine_count = 0;

	// round to nearest, ties toward +infinity, of p / 2^k
	function longint round_down_by(longint p, int k);
		return (p + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function logic signed [31:0] sincos_value(logic signed [31:0] ang, logic cos_mode);
		longint a;
		longint r;
		longint x;
		longint s;
		longint acc;
		longint y;
		longint q;
		longint lim;
		longint terms [5];
		bit neg;
		a = ang;
		// floor modulo into [0, tau), then to q30
		r = a % TAU_Q24;
		if (r < 0)
			r += TAU_Q24;
		r = r <<< UP_SH;
		// fold by quadrant into about [-pi/2, pi/2]
		if (r < PI_Q30) begin
			if (r > HALF_PI_Q30) begin
				x = PI_Q30 - r;
				neg = 1'b1;
			end else begin
				x = r;
				neg = 1'b0;
			end
		end else if (r > PI_Q30 + HALF_PI_Q30) begin
			x = r - TAU_Q30;
			neg = 1'b0;
		end else begin
			x = PI_Q30 - r;
			neg = 1'b1;
		end
		s = round_down_by(x * x, 30);
		// horner evaluation at q32, add terms carry their sign
		if (cos_mode) begin
			acc = -1119;
			terms = '{106347, -5965021, 178956864, -2147483632, longint'(1) <<< 32};
		end else begin
			acc = -103;
			terms = '{11822, -852160, 35791386, -715827882, longint'(1) <<< 32};
		end
		foreach (terms[i])
			acc = round_down_by(acc * s, 30) + terms[i];
		if (cos_mode)
			y = neg ? -acc : acc;
		else
			y = round_down_by(x * acc, 30);
		// output rounding and saturation to plus or minus one
		q = round_down_by(y, 32 - OUT_FB);
		lim = longint'(1) <<< OUT_FB;
		if (q > lim)
			q = lim;
		if (q < -lim)
			q = -lim;
		return q[31:0];
	endfunction

	function void note_angle(logic signed [31:0] ang, logic cos_mode);
		pending_value.push_back(sincos_value(ang, cos_mode));
		pending_angle.push_back(ang);
		pending_mode.push_back(cos_mode);
		if (cos_mode)
			cosine_count++;
		else
			sine_count++;
	endfunction

	function void check_value(logic signed [31:0] got);
		logic signed [31:0] want;
		logic signed [31:0] ang;
		logic cos_mode;
		if (pending_value.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %0d", $time, got);
			errors++;
			return;
		end
		want = pending_value.pop_front();
		ang = pending_angle.pop_front();
		cos_mode = pending_mode.pop_front();
		checked++;
		if (got !== want) begin
			$display("%0t: value mismatch, angle %0d mode %0b: expected %0d, actual %0d",
				$time, ang, cos_mode, want, got);
			errors++;
		end
	endfunction
endclass

module sine_cosine_polynomial_unit_tb;
	localparam int RANDOM_ITEMS = 1800;
	localparam int ANGLE_FB = 24;
	localparam bit [63:0] PI_BITS = 64'hC90FDAA22168C234;
	localparam longint TAU =
		longint'((PI_BITS + (64'd1 << (60 - ANGLE_FB))) >> (61 - ANGLE_FB));

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] angle = '0;
	logic mode = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] value;

	sincos_scoreboard sb = new();
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	int sink_hold = 0;

	sine_cosine_polynomial_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.angle(angle),
		.mode(mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value)
	);

	always #1 clk = ~clk;

	// idle length: mostly short, a few long
	function int pause_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return $urandom_range(1, 3);
		else if (pick < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// one input transaction, optionally after an idle gap
	task send_item(logic signed [31:0] ang, logic cos_mode, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		angle <= ang;
		mode <= cos_mode;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function int source_gap();
		if (src_steady || $urandom_range(0, 2) != 0)
			return 0;
		return pause_len();
	endfunction

	// result side stalls, with stretches of steady ready
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!sink_steady && $urandom_range(0, 3) == 0)
				sink_hold = pause_len();
		end
		if ($urandom_range(0, 199) == 0)
			sink_steady = !sink_steady;
	end

	// watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_angle(angle, mode);
			if (out_valid && out_ready)
				sb.check_value(value);
		end
	end

	initial begin
		longint corner [$];
		longint v;
		int pick;
		corner = '{0, -1, 64'sh7FFFFFFF, -64'sh80000000, TAU / 4, TAU / 4 + 1, TAU / 2,
			3 * TAU / 4, TAU - 1, TAU, -TAU, -3 * TAU};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, quadrant edges and exact multiples of tau in both modes
		foreach (corner[i]) begin
			send_item(corner[i][31:0], 1'b0, source_gap());
			send_item(corner[i][31:0], 1'b1, source_gap());
		end

		// random angles: full range, a few turns around zero, near quadrant edges
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				v = longint'($urandom());
			else if (pick < 8)
				v = longint'($urandom_range(0, 32'(4 * TAU))) - 2 * TAU;
			else
				v = (longint'($urandom_range(0, 16)) - 8) * TAU / 4
					+ longint'($urandom_range(0, 128)) - 64;
			if ($urandom_range(0, 59) == 0)
				src_steady = !src_steady;
			send_item(v[31:0], 1'($urandom_range(0, 1)), source_gap());
		end
		in_valid <= 1'b0;

		while (sb.pending_value.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d sine and %0d cosine angles, %0d results checked",
			sb.sine_count, sb.cosine_count, sb.checked);
		if (sb.errors == 0 && sb.pending_value.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hard stop in case the pipeline hangs
	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", sb.pending_value.size());
		$display("Mismatches found");
		$finish;
	end
endmodule

// ----- sine_cosine_polynomial_unit.f -----
+incdir+hw/rtl
hw/rtl/scpu_pkg.sv
hw/rtl/scpu_horner_step.sv
hw/rtl/sine_cosine_polynomial_unit.sv
sim/sine_cosine_polynomial_unit_tb.sv
